[design/ea2bv_pkg.sv]
// Shared types, constants and arithmetic helpers for the Euler angle to basis vector block.
// Used by ea2bv_cell, ea2bv_sincos and euler_angles_to_basis_vectors; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ea2bv_pkg;

  localparam int ANGLE_BITS       = 16;
  localparam int RESULT_FRAC_BITS = 14;
  localparam int QBITS            = 30;
  localparam int RBITS            = ANGLE_BITS - 3;
  localparam int NSTEP            = 5;
  localparam int DIV_K            = 38;
  localparam int FIELD_W          = 16;
  localparam int TF_SH            = QBITS - RESULT_FRAC_BITS;

  localparam logic [30:0] QONE    = 31'(64'd1 << QBITS);
  localparam logic [29:0] QPI4    = 30'd843314857;
  localparam logic [32:0] TF_HALF = (TF_SH == 0) ? 33'd0 : 33'(64'd1 << (TF_SH - 1));
  localparam logic [32:0] TF_LIM  = 33'(64'd1 << RESULT_FRAC_BITS);

  // Rounded reciprocals ceil(2^38 / d) for the Horner divisors, sine and cosine series.
  localparam logic [37:0] S_RECIP [NSTEP] = '{38'd3817748708, 38'd6544712071,
                                              38'd13743895348, 38'd45812984491, 38'd0};
  localparam logic [6:0]  S_HALF  [NSTEP] = '{7'd36, 7'd21, 7'd10, 7'd3, 7'd0};
  localparam logic [37:0] C_RECIP [NSTEP] = '{38'd3054198967, 38'd4908534053,
                                              38'd9162596899, 38'd22906492246,
                                              38'd137438953472};
  localparam logic [6:0]  C_HALF  [NSTEP] = '{7'd45, 7'd28, 7'd15, 7'd6, 7'd1};

  typedef struct packed {
    logic [30:0] x;
    logic [30:0] x2;
    logic [30:0] ts;
    logic [30:0] tc;
    logic [2:0]  oct;
  } lane_t;

  function automatic logic [30:0] q_mul_u(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] p;
    p = 62'(a) * 62'(b) + (62'd1 << (QBITS - 1));
    return p[60:30];
  endfunction

  // Rounded division by a small constant as a multiply by its scaled reciprocal.
  function automatic logic [30:0] div_recip(input logic [30:0] v, input logic [37:0] m,
                                            input logic [6:0] h);
    logic [69:0] p;
    p = 70'(32'(v) + 32'(h)) * 70'(m);
    return p[DIV_K+30:DIV_K];
  endfunction

  function automatic logic signed [31:0] q_mul_s(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic        neg;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [30:0] m;
    neg = a[31] ^ b[31];
    ma  = a[31] ? 32'(-a) : 32'(a);
    mb  = b[31] ? 32'(-b) : 32'(b);
    m   = q_mul_u(ma[30:0], mb[30:0]);
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  function automatic logic [FIELD_W-1:0] to_field(input logic signed [32:0] v);
    logic        neg;
    logic [32:0] m;
    logic [32:0] r;
    neg = v[32];
    m   = neg ? 33'(-v) : 33'(v);
    m   = (m + TF_HALF) >> TF_SH;
    if (m > TF_LIM) begin
      m = TF_LIM;
    end
    r = neg ? 33'(-m) : m;
    return r[FIELD_W-1:0];
  endfunction

endpackage
`default_nettype wire

[design/ea2bv_cell.sv]
// One Horner step of the sine and cosine series, two register stages deep.
// Depends on ea2bv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ea2bv_cell
  import ea2bv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       en,
  input  wire logic [2:0] step,
  input  wire lane_t      lane_in,
  output lane_t           lane_out
);

  lane_t prod_r;
  lane_t prod_nxt;
  lane_t lane_r;
  lane_t lane_nxt;
  logic  last;

  assign last = (step == 3'(NSTEP - 1));

  always_comb begin
    prod_nxt    = lane_in;
    prod_nxt.ts = q_mul_u(last ? lane_in.x : lane_in.x2, lane_in.ts);
    prod_nxt.tc = q_mul_u(lane_in.x2, lane_in.tc);
  end

  // The sine series ends on a plain multiply by x; every other step is 1 - p/d.
  always_comb begin
    lane_nxt    = prod_r;
    lane_nxt.ts = last ? prod_r.ts
                       : QONE - div_recip(prod_r.ts, S_RECIP[step], S_HALF[step]);
    lane_nxt.tc = QONE - div_recip(prod_r.tc, C_RECIP[step], C_HALF[step]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      lane_r <= lane_nxt;
    end
  end

  assign lane_out = lane_r;

endmodule
`default_nettype wire

[design/ea2bv_sincos.sv]
// Sine and cosine of one binary angle: octant reduction, a chain of Horner cells,
// octant mapping. Depends on ea2bv_pkg and ea2bv_cell.
`timescale 1ns / 1ps
`default_nettype none
module ea2bv_sincos
  import ea2bv_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [ANGLE_BITS-1:0]  angle,
  output logic signed [31:0]          sn,
  output logic signed [31:0]          cs
);

  logic [2:0]       oct0_r;
  logic [RBITS:0]   rr_r;
  logic [2:0]       oct1_r;
  logic [30:0]      x_r;
  lane_t            lane0_r;
  lane_t            chain [NSTEP+1];
  logic [RBITS+30:0] xprod;
  logic [RBITS-1:0] rem;
  logic signed [31:0] si;
  logic signed [31:0] ci;
  logic signed [31:0] sn_nxt;
  logic signed [31:0] cs_nxt;
  logic signed [31:0] sn_r;
  logic signed [31:0] cs_r;

  assign rem   = angle[RBITS-1:0];
  assign xprod = (RBITS+31)'(rr_r) * (RBITS+31)'(QPI4)
               + ((RBITS+31)'(1) << (RBITS - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      oct0_r <= angle[ANGLE_BITS-1:RBITS];
      rr_r   <= angle[RBITS] ? ((RBITS+1)'(1) << RBITS) - (RBITS+1)'(rem)
                             : (RBITS+1)'(rem);
      oct1_r <= oct0_r;
      x_r    <= xprod[RBITS+30:RBITS];
      lane0_r.x   <= x_r;
      lane0_r.x2  <= q_mul_u(x_r, x_r);
      lane0_r.ts  <= QONE;
      lane0_r.tc  <= QONE;
      lane0_r.oct <= oct1_r;
      sn_r <= sn_nxt;
      cs_r <= cs_nxt;
    end
  end

  assign chain[0] = lane0_r;

  for (genvar g = 0; g < NSTEP; g++) begin : g_cell
    ea2bv_cell u_cell (
      .clk      (clk),
      .en       (en),
      .step     (3'(g)),
      .lane_in  (chain[g]),
      .lane_out (chain[g+1])
    );
  end

  assign si = $signed({1'b0, chain[NSTEP].ts});
  assign ci = $signed({1'b0, chain[NSTEP].tc});

  always_comb begin
    case (chain[NSTEP].oct)
      3'd0:    begin sn_nxt = si;  cs_nxt = ci;  end
      3'd1:    begin sn_nxt = ci;  cs_nxt = si;  end
      3'd2:    begin sn_nxt = ci;  cs_nxt = -si; end
      3'd3:    begin sn_nxt = si;  cs_nxt = -ci; end
      3'd4:    begin sn_nxt = -si; cs_nxt = -ci; end
      3'd5:    begin sn_nxt = -ci; cs_nxt = -si; end
      3'd6:    begin sn_nxt = -ci; cs_nxt = si;  end
      default: begin sn_nxt = -si; cs_nxt = ci;  end
    endcase
  end

  assign sn = sn_r;
  assign cs = cs_r;

endmodule
`default_nettype wire

[design/euler_angles_to_basis_vectors.sv]
// Top level: Euler angles to forward, right and up basis vectors in fixed point.
// Depends on ea2bv_pkg and ea2bv_sincos.
`timescale 1ns / 1ps
`default_nettype none
// The block takes one angle triple per item and returns the nine components of the forward,
// right and up unit vectors as signed Q1.14 values, saturated to plus or minus one. It
// accepts an item in every cycle while the output side keeps up. Each angle passes through
// a sine and cosine unit, which reduces it to one octant in three stages, then runs the
// Taylor series through a chain of five Horner cells of two stages each and maps the octant
// back, and three more stages form the products, the sums and the rounding to the output
// width. The whole pipeline advances together; it holds only while a finished result waits
// at the output.
module euler_angles_to_basis_vectors
  import ea2bv_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [47:0]  in_tdata,   // pitch_angle, yaw_angle, roll_angle
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [143:0]      out_tdata   // fwd_x,y,z, rgt_x,y,z, up_x,y,z
);

  localparam int LAT = 17;

  logic               en;
  logic [LAT-1:0]     vld_r;
  logic signed [31:0] sp, cp, sy, cy, sr, cr;
  logic signed [31:0] srsp_r, crsp_r, cpcy_r, cpsy_r, crcp_r, srcp_r;
  logic signed [31:0] sp1_r, sy1_r, cy1_r, sr1_r, cr1_r;
  logic signed [31:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic signed [31:0] cpcy2_r, cpsy2_r, crcp2_r, srcp2_r, sp2_r;
  logic [143:0]       out_r;

  // Every stage moves when the output register is empty or being drained.
  // No item is taken while reset is held, since the valid pipe is being cleared.
  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en && rst_n;

  ea2bv_sincos u_pitch (.clk(clk), .en(en),
    .angle(ANGLE_BITS'(in_tdata[15:0])),  .sn(sp), .cs(cp));
  ea2bv_sincos u_yaw   (.clk(clk), .en(en),
    .angle(ANGLE_BITS'(in_tdata[31:16])), .sn(sy), .cs(cy));
  ea2bv_sincos u_roll  (.clk(clk), .en(en),
    .angle(ANGLE_BITS'(in_tdata[47:32])), .sn(sr), .cs(cr));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // First products, including the shared sr*sp and cr*sp terms.
      srsp_r <= q_mul_s(sr, sp);
      crsp_r <= q_mul_s(cr, sp);
      cpcy_r <= q_mul_s(cp, cy);
      cpsy_r <= q_mul_s(cp, sy);
      crcp_r <= q_mul_s(cr, cp);
      srcp_r <= q_mul_s(sr, cp);
      sp1_r  <= sp;
      sy1_r  <= sy;
      cy1_r  <= cy;
      sr1_r  <= sr;
      cr1_r  <= cr;
      // Second products for the right and up vectors.
      a_r <= q_mul_s(srsp_r, cy1_r);
      b_r <= q_mul_s(srsp_r, sy1_r);
      c_r <= q_mul_s(crsp_r, cy1_r);
      d_r <= q_mul_s(crsp_r, sy1_r);
      e_r <= q_mul_s(cr1_r, sy1_r);
      f_r <= q_mul_s(cr1_r, cy1_r);
      g_r <= q_mul_s(sr1_r, sy1_r);
      h_r <= q_mul_s(sr1_r, cy1_r);
      cpcy2_r <= cpcy_r;
      cpsy2_r <= cpsy_r;
      crcp2_r <= crcp_r;
      srcp2_r <= srcp_r;
      sp2_r   <= sp1_r;
      // Sums, rounding and saturation into the output register.
      out_r <= {to_field(33'(crcp2_r)),
                to_field(33'(d_r) - 33'(h_r)),
                to_field(33'(c_r) + 33'(g_r)),
                to_field(-33'(srcp2_r)),
                to_field(-33'(b_r) - 33'(f_r)),
                to_field(-33'(a_r) + 33'(e_r)),
                to_field(-33'(sp2_r)),
                to_field(33'(cpsy2_r)),
                to_field(33'(cpcy2_r))};
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = out_r;

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
  a_fwd_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) >= -16'sd16384 &&
                    $signed(out_tdata[15:0]) <= 16'sd16384))
    else $error("fwd_x out of range");
  a_up_z_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[143:128]) >= -16'sd16384 &&
                    $signed(out_tdata[143:128]) <= 16'sd16384))
    else $error("up_z out of range");
  a_stall_holds_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire

[test/euler_angles_to_basis_vectors_test.sv]
// Testbench for euler_angles_to_basis_vectors: drives angle triples on the input stream and
// checks all nine basis vector components against an internal fixed point predictor.
// Depends on the block itself.
`timescale 1ns / 1ps

typedef struct {
  logic [15:0] comp [9];
} basis_t;

class basis_scoreboard;
  basis_t pending[$];
  int     errors = 0;

  // Unsigned Q30 product, rounded half up.
  static function longint unsigned mul_u(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  static function longint unsigned div_rnd(longint unsigned v, longint unsigned d);
    return (v + d / 2) / d;
  endfunction

  // Signed product: magnitudes rounded, sign applied afterward.
  static function longint mul_s(longint a, longint b);
    longint unsigned ma, mb, m;
    bit neg;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    m   = mul_u(ma, mb);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  static function void sin_cos(logic [15:0] ang, output longint sn, output longint cs);
    longint unsigned one, r, x, x2, t, s, c;
    logic [2:0] oct;
    one = 64'd1 << 30;
    oct = ang[15:13];
    r   = ang[12:0];
    if (oct[0]) r = (64'd1 << 13) - r;
    x   = (r * 64'd843314857 + (64'd1 << 12)) >> 13;
    x2  = mul_u(x, x);
    t = one - div_rnd(x2, 72);
    t = one - div_rnd(mul_u(x2, t), 42);
    t = one - div_rnd(mul_u(x2, t), 20);
    t = one - div_rnd(mul_u(x2, t), 6);
    s = mul_u(x, t);
    t = one - div_rnd(x2, 90);
    t = one - div_rnd(mul_u(x2, t), 56);
    t = one - div_rnd(mul_u(x2, t), 30);
    t = one - div_rnd(mul_u(x2, t), 12);
    c = one - div_rnd(mul_u(x2, t), 2);
    case (oct)
      3'd0: begin sn = s;  cs = c;  end
      3'd1: begin sn = c;  cs = s;  end
      3'd2: begin sn = c;  cs = -c; cs = -longint'(s); end
      3'd3: begin sn = s;  cs = -longint'(c); end
      3'd4: begin sn = -longint'(s); cs = -longint'(c); end
      3'd5: begin sn = -longint'(c); cs = -longint'(s); end
      3'd6: begin sn = -longint'(c); cs = s; end
      default: begin sn = -longint'(s); cs = c; end
    endcase
  endfunction

  // Q30 to Q1.14 with round half away from zero and saturation at unity.
  static function logic [15:0] to_q14(longint v);
    longint unsigned m;
    longint r;
    m = (v < 0) ? -v : v;
    m = (m + (64'd1 << 15)) >> 16;
    if (m > (64'd1 << 14)) m = 64'd1 << 14;
    r = (v < 0) ? -longint'(m) : longint'(m);
    return r[15:0];
  endfunction

  function void note_angles(logic [15:0] pitch, logic [15:0] yaw, logic [15:0] roll);
    longint sp, cp, sy, cy, sr, cr, srsp, crsp;
    basis_t b;
    sin_cos(pitch, sp, cp);
    sin_cos(yaw, sy, cy);
    sin_cos(roll, sr, cr);
    srsp = mul_s(sr, sp);
    crsp = mul_s(cr, sp);
    b.comp[0] = to_q14(mul_s(cp, cy));
    b.comp[1] = to_q14(mul_s(cp, sy));
    b.comp[2] = to_q14(-sp);
    b.comp[3] = to_q14(-mul_s(srsp, cy) + mul_s(cr, sy));
    b.comp[4] = to_q14(-mul_s(srsp, sy) - mul_s(cr, cy));
    b.comp[5] = to_q14(-mul_s(sr, cp));
    b.comp[6] = to_q14(mul_s(crsp, cy) + mul_s(sr, sy));
    b.comp[7] = to_q14(mul_s(crsp, sy) - mul_s(sr, cy));
    b.comp[8] = to_q14(mul_s(cr, cp));
    pending.push_back(b);
  endfunction

  function void check_vectors(logic [143:0] data);
    string names [9] = '{"fwd_x", "fwd_y", "fwd_z", "rgt_x", "rgt_y", "rgt_z",
                         "up_x", "up_y", "up_z"};
    basis_t b;
    if (pending.size() == 0) begin
      $error("result arrived with no item outstanding: %h", data);
      errors++;
      return;
    end
    b = pending.pop_front();
    for (int i = 0; i < 9; i++) begin
      if (data[16*i +: 16] !== b.comp[i]) begin
        $error("%s expected %0d actual %0d", names[i], $signed(b.comp[i]),
               $signed(data[16*i +: 16]));
        errors++;
      end
    end
  endfunction
endclass

module euler_angles_to_basis_vectors_test;
  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [47:0]  in_tdata = '0;    // pitch_angle, yaw_angle, roll_angle
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;        // fwd_x,y,z, rgt_x,y,z, up_x,y,z

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  basis_scoreboard board = new();

  euler_angles_to_basis_vectors uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: random stalls, check on every accepted result.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_vectors(out_tdata);
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Sends one triple, idling beforehand by the current rate, and waits for acceptance.
  task automatic send_angles(logic [15:0] pitch, logic [15:0] yaw, logic [15:0] roll);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {roll, yaw, pitch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_angles(pitch, yaw, roll);
  endtask

  // One angle in four is an octant boundary with a small offset, to stress rounding and saturation.
  function automatic logic [15:0] rand_angle();
    if ($urandom_range(3) == 0)
      return 16'(($urandom_range(7) << 13) + $urandom_range(6) - 3);
    return 16'($urandom);
  endfunction

  initial begin
    logic [15:0] corners [10] = '{16'h0000, 16'hFFFF, 16'h2000, 16'h4000, 16'h8000,
                                  16'hC000, 16'h1FFF, 16'h6000, 16'hA001, 16'hE000};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every cardinal angle and every octant boundary but A000 on each axis, plus all-ones.
    for (int i = 0; i < 10; i++) send_angles(corners[i], corners[(i + 3) % 10],
                                            corners[(i + 7) % 10]);
    send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_angles(16'h5555, 16'hAAAA, 16'h0001);
    send_angles(16'hAAAA, 16'h5555, 16'h8001);

    // Random phases: free flowing, idle sender, stalling receiver, both.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 71 : (phase == 3) ? 36 : 0;
      recv_stall_pct = (phase == 2) ? 71 : (phase == 3) ? 36 : 0;
      repeat (272) send_angles(rand_angle(), rand_angle(), rand_angle());
    end
    in_tvalid <= 1'b0;
    recv_stall_pct = 0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
